// ===== hw/rtl/qlp_pkg.sv =====
// ----------------------------------------------------------------------------
// qlp_pkg: shared types and constants of the low-order point finder
// Field widths, register indexes, reset values and item types.
// ----------------------------------------------------------------------------
package qlp_pkg;

  // fixed field widths
  localparam int KIND_W     = 8;
  localparam int Q_W        = 24;
  localparam int POS_W      = 10;
  localparam int EXT_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // arithmetic widths of the minor evaluation
  localparam int EL_W  = 27;  // entries of 2*thr*I - 3*Q
  localparam int OP_W  = 28;  // multiplier operands
  localparam int PR_W  = 56;  // multiplier product
  localparam int CL_W  = 27;  // low slice of a cofactor
  localparam int CC_W  = 54;  // 2x2 minors and cofactors
  localparam int DET_W = 84;  // full determinant

  // defaults
  localparam int MAX_EXTENT_DEF = 1024;
  localparam int FRAC_BITS      = 20;
  localparam int EXT_RESET      = 64;
  // 0.60 rounded to nearest in FRAC_BITS fraction bits
  localparam int THR_RESET      = (6 * (2 ** FRAC_BITS) + 5) / 10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EXT_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXT_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXT_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THR   = 2'd3;

  // cell classes that are examined
  localparam logic [KIND_W-1:0] KIND_BULK = 8'd0;
  localparam logic [KIND_W-1:0] KIND_SURF = 8'd1;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] wdata;
  } qlp_cfg_wr_t;

  typedef struct packed {
    logic [KIND_W-1:0]     cell_kind;
    logic signed [Q_W-1:0] q_xx;
    logic signed [Q_W-1:0] q_xy;
    logic signed [Q_W-1:0] q_xz;
    logic signed [Q_W-1:0] q_yy;
    logic signed [Q_W-1:0] q_yz;
    logic signed [Q_W-1:0] q_zz;
  } qlp_point_t;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
  } qlp_pos_t;

  typedef struct packed {
    logic                  examine;
    qlp_pos_t              pos;
    logic signed [Q_W-1:0] q_xx;
    logic signed [Q_W-1:0] q_xy;
    logic signed [Q_W-1:0] q_xz;
    logic signed [Q_W-1:0] q_yy;
    logic signed [Q_W-1:0] q_yz;
    logic signed [Q_W-1:0] q_zz;
  } qlp_entry_t;

endpackage

// ===== hw/rtl/qlp_if.sv =====
// ----------------------------------------------------------------------------
// qlp_if: valid/ready channels of the low-order point finder
// Point input channel, position result channel and the internal queue channel.
// ----------------------------------------------------------------------------
interface qlp_in_if;
  logic               valid;
  logic               ready;
  qlp_pkg::qlp_point_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qlp_out_if;
  logic             valid;
  logic             ready;
  qlp_pkg::qlp_pos_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qlp_entry_if;
  logic               valid;
  logic               ready;
  qlp_pkg::qlp_entry_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/qtensor_low_order_point_finder.sv =====
// ----------------------------------------------------------------------------
// qtensor_low_order_point_finder: flags grid points of low nematic order
// Counts grid coordinates over a streamed Q-tensor field and reports the
// position of every bulk or surface point whose scalar order is below the
// threshold, tested exactly as positive definiteness of 2*thr*I - 3*Q.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake          payload
//   -------   ---  -----------------  -----------------------------------------
//   in_ch     in   valid/ready        cell_kind, q_xx q_xy q_xz q_yy q_yz q_zz
//   out_ch    out  valid/ready        pos_x, pos_y, pos_z
//   cfg       in   cfg_we_i (no wait) cfg_idx_i, cfg_wdata_i
//
// An examined point is loaded into the back sequencer, which then takes 19
// steps through its single registered 28x28 multiplier. A skipped class is
// popped from the queue and dropped. The two-entry queue takes up to two items
// while the back works, then drops input ready. A result holds in the output
// register; the sequencer waits at its decision step while that is still full.
// Reset clears counters, queue and sequencer; extents 64, threshold 0.60.
//
module qtensor_low_order_point_finder #(
  parameter int MAX_EXTENT = qlp_pkg::MAX_EXTENT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [qlp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [qlp_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  qlp_in_if.sink                           in_ch,
  qlp_out_if.source                        out_ch
);

  qlp_pkg::qlp_cfg_wr_t           cfg_wr;
  logic signed [qlp_pkg::Q_W-1:0] thr;

  qlp_entry_if push_if ();
  qlp_entry_if pop_if ();

  assign cfg_wr.we    = cfg_we_i;
  assign cfg_wr.idx   = cfg_idx_i;
  assign cfg_wr.wdata = cfg_wdata_i;

  // tag points with coordinates, advance the grid counters
  qlp_front #(
    .MAX_EXTENT(MAX_EXTENT)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_wr),
    .thr_o  (thr),
    .in_ch  (in_ch),
    .ent_ch (push_if)
  );

  // decouple classification from the minor evaluation
  qlp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_ch (push_if),
    .pop_ch  (pop_if)
  );

  // exact threshold test and result register
  qlp_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .thr_i  (thr),
    .ent_ch (pop_if),
    .out_ch (out_ch)
  );

endmodule

// ===== hw/rtl/qlp_front.sv =====
// ----------------------------------------------------------------------------
// qlp_front: configuration, grid counters and classification
// Tags each accepted point with its coordinates and pushes it to the queue.
// ----------------------------------------------------------------------------
module qlp_front #(
  parameter int MAX_EXTENT = qlp_pkg::MAX_EXTENT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  qlp_pkg::qlp_cfg_wr_t          cfg_i,
  output logic signed [qlp_pkg::Q_W-1:0] thr_o,
  qlp_in_if.sink                        in_ch,
  qlp_entry_if.source                   ent_ch
);

  localparam int CW    = $clog2(MAX_EXTENT);
  localparam int CMP_W = (CW + 1 > qlp_pkg::EXT_W) ? CW + 1 : qlp_pkg::EXT_W;

  logic [qlp_pkg::EXT_W-1:0] ext_x_q, ext_y_q, ext_z_q;
  logic signed [qlp_pkg::Q_W-1:0] thr_q;
  logic [CW-1:0] cnt_x_q, cnt_x_d, cnt_y_q, cnt_y_d, cnt_z_q, cnt_z_d;
  logic [CMP_W-1:0] nx, ny, nz;
  logic wrap_x, wrap_y, wrap_z;
  logic accept;

  // zero counts as one, large values saturate
  function automatic logic [CMP_W-1:0] eff_ext(input logic [qlp_pkg::EXT_W-1:0] e);
    logic [CMP_W-1:0] ee;
    ee = CMP_W'(e);
    if (e == '0) begin
      ee = CMP_W'(1);
    end else if (ee > CMP_W'(MAX_EXTENT)) begin
      ee = CMP_W'(MAX_EXTENT);
    end
    return ee;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_x_q <= qlp_pkg::EXT_W'(qlp_pkg::EXT_RESET);
      ext_y_q <= qlp_pkg::EXT_W'(qlp_pkg::EXT_RESET);
      ext_z_q <= qlp_pkg::EXT_W'(qlp_pkg::EXT_RESET);
      thr_q   <= qlp_pkg::Q_W'(qlp_pkg::THR_RESET);
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        qlp_pkg::CFG_EXT_X: ext_x_q <= cfg_i.wdata[qlp_pkg::EXT_W-1:0];
        qlp_pkg::CFG_EXT_Y: ext_y_q <= cfg_i.wdata[qlp_pkg::EXT_W-1:0];
        qlp_pkg::CFG_EXT_Z: ext_z_q <= cfg_i.wdata[qlp_pkg::EXT_W-1:0];
        qlp_pkg::CFG_THR:   thr_q   <= cfg_i.wdata[qlp_pkg::Q_W-1:0];
        default: ;
      endcase
    end
  end

  assign thr_o = thr_q;

  assign accept = in_ch.valid && ent_ch.ready;

  always_comb begin
    nx = CMP_W'(cnt_x_q) + CMP_W'(1);
    ny = CMP_W'(cnt_y_q) + CMP_W'(1);
    nz = CMP_W'(cnt_z_q) + CMP_W'(1);
    wrap_x = nx >= eff_ext(ext_x_q);
    wrap_y = ny >= eff_ext(ext_y_q);
    wrap_z = nz >= eff_ext(ext_z_q);
    cnt_x_d = cnt_x_q;
    cnt_y_d = cnt_y_q;
    cnt_z_d = cnt_z_q;
    if (accept) begin
      cnt_x_d = wrap_x ? '0 : CW'(nx);
      if (wrap_x) begin
        cnt_y_d = wrap_y ? '0 : CW'(ny);
        if (wrap_y) begin
          cnt_z_d = wrap_z ? '0 : CW'(nz);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_x_q <= '0;
      cnt_y_q <= '0;
      cnt_z_q <= '0;
    end else begin
      cnt_x_q <= cnt_x_d;
      cnt_y_q <= cnt_y_d;
      cnt_z_q <= cnt_z_d;
    end
  end

  assign in_ch.ready  = ent_ch.ready;
  assign ent_ch.valid = in_ch.valid;

  always_comb begin
    ent_ch.data.examine = in_ch.data.cell_kind inside {qlp_pkg::KIND_BULK, qlp_pkg::KIND_SURF};
    ent_ch.data.pos.pos_x = qlp_pkg::POS_W'(cnt_x_q);
    ent_ch.data.pos.pos_y = qlp_pkg::POS_W'(cnt_y_q);
    ent_ch.data.pos.pos_z = qlp_pkg::POS_W'(cnt_z_q);
    ent_ch.data.q_xx = in_ch.data.q_xx;
    ent_ch.data.q_xy = in_ch.data.q_xy;
    ent_ch.data.q_xz = in_ch.data.q_xz;
    ent_ch.data.q_yy = in_ch.data.q_yy;
    ent_ch.data.q_yz = in_ch.data.q_yz;
    ent_ch.data.q_zz = in_ch.data.q_zz;
  end

endmodule

// ===== hw/rtl/qlp_queue.sv =====
// ----------------------------------------------------------------------------
// qlp_queue: two-entry queue between front and back
// Lets the front keep accepting while the back works on an item.
// ----------------------------------------------------------------------------
module qlp_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  qlp_entry_if.sink   push_ch,
  qlp_entry_if.source pop_ch
);

  qlp_pkg::qlp_entry_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign push_ch.ready = (cnt_q != 2'd2);
  assign pop_ch.valid  = (cnt_q != 2'd0);
  assign pop_ch.data   = mem_q[rd_ptr_q];

  assign do_push = push_ch.valid && push_ch.ready;
  assign do_pop  = pop_ch.valid && pop_ch.ready;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_ch.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== hw/rtl/qlp_back.sv =====
// ----------------------------------------------------------------------------
// qlp_back: positive definiteness test of 2*thr*I - 3*Q
// Sequences the leading minors through one registered 28x28 multiplier.
// ----------------------------------------------------------------------------
module qlp_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic signed [qlp_pkg::Q_W-1:0] thr_i,
  qlp_entry_if.sink                      ent_ch,
  qlp_out_if.source                      out_ch
);

  localparam int EL_W  = qlp_pkg::EL_W;
  localparam int OP_W  = qlp_pkg::OP_W;
  localparam int PR_W  = qlp_pkg::PR_W;
  localparam int CC_W  = qlp_pkg::CC_W;
  localparam int CL_W  = qlp_pkg::CL_W;
  localparam int DET_W = qlp_pkg::DET_W;

  // sequencer steps: most name the multiply issued in them; the product of the
  // previous step is folded into its accumulator in the same cycle
  localparam logic [4:0] S_D1D2   = 5'd0;
  localparam logic [4:0] S_A12SQ  = 5'd1;
  localparam logic [4:0] S_D2D3   = 5'd2;
  localparam logic [4:0] S_A23SQ  = 5'd3;
  localparam logic [4:0] S_C1FIN  = 5'd4;
  localparam logic [4:0] S_C1LO   = 5'd5;
  localparam logic [4:0] S_C1HI   = 5'd6;
  localparam logic [4:0] S_A12D3  = 5'd7;
  localparam logic [4:0] S_A23A13 = 5'd8;
  localparam logic [4:0] S_C2FIN  = 5'd9;
  localparam logic [4:0] S_C2LO   = 5'd10;
  localparam logic [4:0] S_C2HI   = 5'd11;
  localparam logic [4:0] S_A12A23 = 5'd12;
  localparam logic [4:0] S_D2A13  = 5'd13;
  localparam logic [4:0] S_C3FIN  = 5'd14;
  localparam logic [4:0] S_C3LO   = 5'd15;
  localparam logic [4:0] S_C3HI   = 5'd16;
  localparam logic [4:0] S_DETFIN = 5'd17;
  localparam logic [4:0] S_DECIDE = 5'd18;
  localparam logic [4:0] S_IDLE   = 5'd19;

  logic [4:0] state_q, state_d;

  logic signed [EL_W-1:0] d1_q, d2_q, d3_q, a12_q, a13_q, a23_q;
  logic signed [EL_W-1:0] t2, d1_n, d2_n, d3_n, a12_n, a13_n, a23_n;
  qlp_pkg::qlp_pos_t pos_q;

  logic signed [OP_W-1:0]  mul_a, mul_b, c_lo, c_hi;
  logic signed [PR_W-1:0]  prod_d, prod_q;
  logic signed [CC_W-1:0]  prod_cc, m2_q, m2_d, cc_q, cc_d;
  logic signed [DET_W-1:0] prod_det, prod_det_hi, det_q, det_d;

  logic              out_valid_q, out_valid_d, out_free, hit, load;
  qlp_pkg::qlp_pos_t out_pos_q, out_pos_d;

  // entries: diagonal 2*thr - 3*q, off diagonal -3*q
  function automatic logic signed [EL_W-1:0] triple(input logic signed [qlp_pkg::Q_W-1:0] q);
    logic signed [EL_W-1:0] w;
    w = EL_W'(q);
    return (w <<< 1) + w;
  endfunction

  always_comb begin
    t2    = EL_W'(thr_i) <<< 1;
    d1_n  = t2 - triple(ent_ch.data.q_xx);
    d2_n  = t2 - triple(ent_ch.data.q_yy);
    d3_n  = t2 - triple(ent_ch.data.q_zz);
    a12_n = -triple(ent_ch.data.q_xy);
    a13_n = -triple(ent_ch.data.q_xz);
    a23_n = -triple(ent_ch.data.q_yz);
  end

  // take the next item only when free; drop unexamined classes on the spot
  assign ent_ch.ready = (state_q == S_IDLE);
  assign load = ent_ch.valid && ent_ch.ready && ent_ch.data.examine;

  always_ff @(posedge clk_i) begin
    if (load) begin
      d1_q  <= d1_n;
      d2_q  <= d2_n;
      d3_q  <= d3_n;
      a12_q <= a12_n;
      a13_q <= a13_n;
      a23_q <= a23_n;
      pos_q <= ent_ch.data.pos;
    end
  end

  // cofactor split: unsigned low slice, signed high slice
  assign c_lo = OP_W'(cc_q[CL_W-1:0]);
  assign c_hi = OP_W'(cc_q >>> CL_W);

  assign prod_d      = mul_a * mul_b;
  assign prod_cc     = CC_W'(prod_q);
  assign prod_det    = DET_W'(prod_q);
  assign prod_det_hi = prod_det <<< CL_W;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    m2_d  = m2_q;
    cc_d  = cc_q;
    det_d = det_q;
    case (state_q)
      S_D1D2: begin
        mul_a = OP_W'(d1_q);
        mul_b = OP_W'(d2_q);
      end
      S_A12SQ: begin
        mul_a = OP_W'(a12_q);
        mul_b = OP_W'(a12_q);
        m2_d  = prod_cc;
      end
      S_D2D3: begin
        mul_a = OP_W'(d2_q);
        mul_b = OP_W'(d3_q);
        m2_d  = m2_q - prod_cc;
      end
      S_A23SQ: begin
        mul_a = OP_W'(a23_q);
        mul_b = OP_W'(a23_q);
        cc_d  = prod_cc;
      end
      S_C1FIN: cc_d = cc_q - prod_cc;
      S_C1LO: begin
        mul_a = OP_W'(d1_q);
        mul_b = c_lo;
      end
      S_C1HI: begin
        mul_a = OP_W'(d1_q);
        mul_b = c_hi;
        det_d = prod_det;
      end
      S_A12D3: begin
        mul_a = OP_W'(a12_q);
        mul_b = OP_W'(d3_q);
        det_d = det_q + prod_det_hi;
      end
      S_A23A13: begin
        mul_a = OP_W'(a23_q);
        mul_b = OP_W'(a13_q);
        cc_d  = prod_cc;
      end
      S_C2FIN: cc_d = cc_q - prod_cc;
      S_C2LO: begin
        mul_a = OP_W'(a12_q);
        mul_b = c_lo;
      end
      S_C2HI: begin
        mul_a = OP_W'(a12_q);
        mul_b = c_hi;
        det_d = det_q - prod_det;
      end
      S_A12A23: begin
        mul_a = OP_W'(a12_q);
        mul_b = OP_W'(a23_q);
        det_d = det_q - prod_det_hi;
      end
      S_D2A13: begin
        mul_a = OP_W'(d2_q);
        mul_b = OP_W'(a13_q);
        cc_d  = prod_cc;
      end
      S_C3FIN: cc_d = cc_q - prod_cc;
      S_C3LO: begin
        mul_a = OP_W'(a13_q);
        mul_b = c_lo;
      end
      S_C3HI: begin
        mul_a = OP_W'(a13_q);
        mul_b = c_hi;
        det_d = det_q + prod_det;
      end
      S_DETFIN: det_d = det_q + prod_det_hi;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    m2_q   <= m2_d;
    cc_q   <= cc_d;
    det_q  <= det_d;
  end

  assign hit = !d1_q[EL_W-1] && (d1_q != '0)
            && !m2_q[CC_W-1] && (m2_q != '0)
            && !det_q[DET_W-1] && (det_q != '0);

  assign out_free = !out_valid_q || out_ch.ready;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ch.ready;
    out_pos_d   = out_pos_q;
    case (state_q)
      S_IDLE: begin
        if (load) begin
          state_d = S_D1D2;
        end
      end
      S_DECIDE: begin
        // hold until the output register can take the result
        if (out_free) begin
          state_d = S_IDLE;
          if (hit) begin
            out_valid_d = 1'b1;
            out_pos_d   = pos_q;
          end
        end
      end
      default: state_d = state_q + 5'd1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_pos_q <= out_pos_d;
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_pos_q;

endmodule

// ===== tb/tb_qtensor_low_order_point_finder.sv =====
// ----------------------------------------------------------------------------
// tb_qtensor_low_order_point_finder: self-checking bench of the point finder
// Streams Q-tensor grid points through the valid/ready input, predicts every
// low-order position with an exact minor test and a shadow of the grid
// counters, and compares each output item field by field under random gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_qtensor_low_order_point_finder;
  import qlp_pkg::*;

  localparam int MAX_EXT      = MAX_EXTENT_DEF;
  localparam int DRAIN_CYCLES = 80;     // two queued points through the sequencer, plus slack
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_ITEMS  = 84;
  localparam int LIMIT_NS     = 3000000;

  localparam logic signed [Q_W-1:0] QP = 24'sh7FFFFF;
  localparam logic signed [Q_W-1:0] QN = 24'sh800000;

  typedef logic signed [127:0] wide_t;

  typedef enum logic {ROW_POINT, ROW_WRITE} row_op_e;

  // one row of the directed table: either a register write or a point item,
  // optionally with the expected outcome written out by hand
  typedef struct packed {
    row_op_e               op;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] wdata;
    logic [KIND_W-1:0]     kind;
    logic signed [Q_W-1:0] xx;
    logic signed [Q_W-1:0] xy;
    logic signed [Q_W-1:0] xz;
    logic signed [Q_W-1:0] yy;
    logic signed [Q_W-1:0] yz;
    logic signed [Q_W-1:0] zz;
    bit                    typed;
    bit                    hit;
    logic [POS_W-1:0]      px;
    logic [POS_W-1:0]      py;
    logic [POS_W-1:0]      pz;
  } dir_row_t;

  // threshold is 0.60 and all extents 64 at the top of the table
  localparam dir_row_t DIR_TAB [25] = '{
    // isotropic points of both examined classes qualify at once
    '{ROW_POINT, '0, 0, KIND_BULK, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0},
    '{ROW_POINT, '0, 0, KIND_SURF, 0, 0, 0, 0, 0, 0, 1, 1, 1, 0, 0},
    // other classes are skipped but still advance the counters
    '{ROW_POINT, '0, 0, 8'd2,      0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0},
    '{ROW_POINT, '0, 0, 8'd255,    0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0},
    // field extremes
    '{ROW_POINT, '0, 0, KIND_BULK, QP, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0},
    '{ROW_POINT, '0, 0, KIND_SURF, QN, 0, 0, QN, 0, QN, 1, 1, 5, 0, 0},
    '{ROW_POINT, '0, 0, KIND_BULK, QN, QN, QN, QN, QN, QN, 0, 0, 0, 0, 0},
    '{ROW_POINT, '0, 0, KIND_BULK, 0, QP, QP, 0, QP, 0, 0, 0, 0, 0, 0},
    // first minor just above zero, then zero crossed on each minor in turn
    '{ROW_POINT, '0, 0, KIND_BULK, 419430, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_POINT, '0, 0, KIND_BULK, 419431, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_POINT, '0, 0, KIND_BULK, 0, 0, 0, 419431, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_POINT, '0, 0, KIND_SURF, 0, 0, 0, 0, 0, 419431, 0, 0, 0, 0, 0},
    '{ROW_POINT, '0, 0, KIND_BULK, 200000, -300000, 150000, 100000, 250000, -50000,
      0, 0, 0, 0, 0},
    // shrink x below the running counter: it wraps on the next advance
    '{ROW_WRITE, CFG_EXT_X, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_POINT, '0, 0, KIND_BULK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_POINT, '0, 0, KIND_SURF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // zero extents count as one, oversized ones saturate
    '{ROW_WRITE, CFG_EXT_X, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, CFG_EXT_Y, 2047, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, CFG_EXT_Z, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_POINT, '0, 0, KIND_BULK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // most negative threshold: only strongly negative tensors qualify
    '{ROW_WRITE, CFG_THR, 24'h800000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_POINT, '0, 0, KIND_BULK, QN, 0, 0, QN, 0, QN, 0, 0, 0, 0, 0},
    '{ROW_POINT, '0, 0, KIND_BULK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // largest threshold, diagonal two steps inside the boundary
    '{ROW_WRITE, CFG_THR, 24'h7FFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_POINT, '0, 0, KIND_SURF, 5592404, 0, 0, 5592404, 0, 5592404, 0, 0, 0, 0, 0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  qlp_in_if  in_ch ();
  qlp_out_if out_ch ();

  qtensor_low_order_point_finder #(
    .MAX_EXTENT (MAX_EXT)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // shadow copy of the registers and grid counters
  logic [EXT_W-1:0]      ext_x_sh, ext_y_sh, ext_z_sh;
  logic signed [Q_W-1:0] thr_sh;
  int unsigned           cnt_x, cnt_y, cnt_z;

  qlp_pos_t pending_pos [$];   // positions still owed by the block, oldest first
  qlp_pos_t want_pos;
  int       n_err      = 0;
  int       n_sent     = 0;
  int       n_found    = 0;
  int       n_settings = 0;
  bit       calm       = 1'b0;  // suppress idling on both sides
  int       ready_hold = 0;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Mostly back to back, now and then a few cycles, rarely a long pause.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int unsigned eff_extent(logic [EXT_W-1:0] e);
    if (e == 0) return 1;
    if (e > MAX_EXT) return MAX_EXT;
    return 32'(e);
  endfunction

  // Exact test: 2*thr*I - 3*Q positive definite, all leading minors above zero.
  function automatic bit below_order(qlp_point_t p, logic signed [Q_W-1:0] thr);
    wide_t t2, d1, d2, d3, a12, a13, a23, m2, c1, c2, c3, det;
    t2  = wide_t'(thr) * 2;
    d1  = t2 - 3 * wide_t'($signed(p.q_xx));
    d2  = t2 - 3 * wide_t'($signed(p.q_yy));
    d3  = t2 - 3 * wide_t'($signed(p.q_zz));
    a12 = -3 * wide_t'($signed(p.q_xy));
    a13 = -3 * wide_t'($signed(p.q_xz));
    a23 = -3 * wide_t'($signed(p.q_yz));
    m2  = d1 * d2 - a12 * a12;
    c1  = d2 * d3 - a23 * a23;
    c2  = a12 * d3 - a23 * a13;
    c3  = a12 * a23 - d2 * a13;
    det = d1 * c1 - a12 * c2 + a13 * c3;
    return (d1 > 0) && (m2 > 0) && (det > 0);
  endfunction

  // Decide the outcome of one accepted point, then advance the grid counters.
  function automatic void grid_point(input qlp_point_t p, output bit hit,
                                     output qlp_pos_t pos);
    hit = ((p.cell_kind == KIND_BULK) || (p.cell_kind == KIND_SURF)) &&
          below_order(p, thr_sh);
    pos.pos_x = cnt_x[POS_W-1:0];
    pos.pos_y = cnt_y[POS_W-1:0];
    pos.pos_z = cnt_z[POS_W-1:0];
    // a counter at or past a shrunken extent wraps on this advance
    cnt_x = cnt_x + 1;
    if (cnt_x >= eff_extent(ext_x_sh)) begin
      cnt_x = 0;
      cnt_y = cnt_y + 1;
      if (cnt_y >= eff_extent(ext_y_sh)) begin
        cnt_y = 0;
        cnt_z = cnt_z + 1;
        if (cnt_z >= eff_extent(ext_z_sh)) cnt_z = 0;
      end
    end
  endfunction

  function automatic logic signed [Q_W-1:0] clamp_q(longint v);
    if (v > 64'sd8388607) return QP;
    if (v < -64'sd8388608) return QN;
    return v[Q_W-1:0];
  endfunction

  function automatic int pick_extent();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 6);
    if (r < 70) return 0;
    if (r < 80) return $urandom_range(1024, 2047);
    return $urandom_range(1, 1024);
  endfunction

  // Random point: some fully random tensors, most of them placed around the
  // current threshold so that both outcomes and every minor failing show up.
  function automatic qlp_point_t rand_point();
    qlp_point_t p;
    longint     base, spread, off;
    longint     dg [3];
    longint     od [3];
    int         r, k, i;
    r = $urandom_range(0, 99);
    p.cell_kind = (r < 80) ? KIND_W'($urandom_range(0, 1)) : KIND_W'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 20) begin
      p.q_xx = Q_W'($urandom());
      p.q_xy = Q_W'($urandom());
      p.q_xz = Q_W'($urandom());
      p.q_yy = Q_W'($urandom());
      p.q_yz = Q_W'($urandom());
      p.q_zz = Q_W'($urandom());
    end else begin
      k      = $urandom_range(2, 21);
      base   = (2 * longint'(thr_sh)) / 3;
      spread = longint'(1) << (k - 2);
      for (i = 0; i < 3; i++) begin
        off = longint'($urandom_range(0, 1 << k));
        if ($urandom_range(0, 3) == 0) off = -off;
        dg[i] = base - off;
        od[i] = longint'($urandom_range(0, 32'(2 * spread))) - spread;
      end
      p.q_xx = clamp_q(dg[0]);
      p.q_yy = clamp_q(dg[1]);
      p.q_zz = clamp_q(dg[2]);
      p.q_xy = clamp_q(od[0]);
      p.q_xz = clamp_q(od[1]);
      p.q_yz = clamp_q(od[2]);
    end
    return p;
  endfunction

  // Offer one point, hold it until accepted, record what it should produce.
  task automatic send_point(input qlp_point_t p, input bit typed, input bit t_hit,
                            input qlp_pos_t t_pos);
    bit       hit;
    qlp_pos_t pos;
    in_ch.valid <= 1'b1;
    in_ch.data  <= p;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    grid_point(p, hit, pos);
    if (typed) begin
      hit = t_hit;
      pos = t_pos;
    end
    if (hit) pending_pos.push_back(pos);
    n_sent++;
  endtask

  task automatic idle_in();
    int g;
    g = calm ? 0 : gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Hold the sender until every owed position is out, then let skipped or
  // failing points still in the pipeline finish.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_pos.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_EXT_X: ext_x_sh = data[EXT_W-1:0];
      CFG_EXT_Y: ext_y_sh = data[EXT_W-1:0];
      CFG_EXT_Z: ext_z_sh = data[EXT_W-1:0];
      CFG_THR:   thr_sh   = data[Q_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Random stalls on the result side.
  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      out_ch.ready <= 1'b0;
      ready_hold = ready_hold - 1;
    end else begin
      ready_hold = calm ? 0 : gap_len();
      out_ch.ready <= (ready_hold == 0);
    end
  end

  // Compare every accepted position with the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_pos.size() == 0) begin
        $error("unexpected position item x=%0d y=%0d z=%0d",
               out_ch.data.pos_x, out_ch.data.pos_y, out_ch.data.pos_z);
        n_err++;
      end else begin
        want_pos = pending_pos.pop_front();
        n_found++;
        if (out_ch.data.pos_x !== want_pos.pos_x) begin
          $error("pos_x: expected %0d, got %0d", want_pos.pos_x, out_ch.data.pos_x);
          n_err++;
        end
        if (out_ch.data.pos_y !== want_pos.pos_y) begin
          $error("pos_y: expected %0d, got %0d", want_pos.pos_y, out_ch.data.pos_y);
          n_err++;
        end
        if (out_ch.data.pos_z !== want_pos.pos_z) begin
          $error("pos_z: expected %0d, got %0d", want_pos.pos_z, out_ch.data.pos_z);
          n_err++;
        end
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout: %0d positions still owed", pending_pos.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    dir_row_t   row;
    qlp_point_t p;
    qlp_pos_t   tpos;
    int         ph, n, ex, ey, ez, thr;

    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    ext_x_sh = EXT_W'(EXT_RESET);
    ext_y_sh = EXT_W'(EXT_RESET);
    ext_z_sh = EXT_W'(EXT_RESET);
    thr_sh   = Q_W'(THR_RESET);
    cnt_x    = 0;
    cnt_y    = 0;
    cnt_z    = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: writes only with the block idle, points checked either
    // against the written outcome or the predictor
    n_settings = 1;
    foreach (DIR_TAB[i]) begin
      row = DIR_TAB[i];
      if (row.op == ROW_WRITE) begin
        settle();
        write_reg(row.idx, row.wdata);
        n_settings++;
      end else begin
        p.cell_kind = row.kind;
        p.q_xx = row.xx;
        p.q_xy = row.xy;
        p.q_xz = row.xz;
        p.q_yy = row.yy;
        p.q_yz = row.yz;
        p.q_zz = row.zz;
        tpos.pos_x = row.px;
        tpos.pos_y = row.py;
        tpos.pos_z = row.pz;
        send_point(p, row.typed, row.hit, tpos);
        idle_in();
      end
    end

    // random phases: drain (sender holds until all results are back), write
    // all four registers, then stream points
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      ex = pick_extent();
      ey = pick_extent();
      ez = pick_extent();
      case (ph)
        0: begin
          ex  = 3;
          ey  = 2;
          ez  = 2;
          thr = THR_RESET;
        end
        1: begin
          ex  = 2047;
          ey  = 0;
          ez  = 1024;
          thr = 32'sh007FFFFF;
        end
        2: thr = -32'sd8388608;
        3: thr = 0;
        4: thr = $urandom();
        default: thr = -int'($urandom_range(1, 4000000));
      endcase
      // junk above the extent width must be dropped
      write_reg(CFG_EXT_X, CFG_DATA_W'(($urandom() & 32'hFFF800) | ex));
      write_reg(CFG_EXT_Y, CFG_DATA_W'(($urandom() & 32'hFFF800) | ey));
      write_reg(CFG_EXT_Z, CFG_DATA_W'(($urandom() & 32'hFFF800) | ez));
      write_reg(CFG_THR, CFG_DATA_W'(thr));
      n_settings++;
      calm = (ph == 0) || (ph == 3);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_point(rand_point(), 1'b0, 1'b0, '0);
        idle_in();
      end
    end

    calm = 1'b0;
    in_ch.valid <= 1'b0;
    while (pending_pos.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d grid points streamed under %0d register settings", n_sent, n_settings);
    $display("%0d low-order positions compared, %0d mismatching fields", n_found, n_err);
    if (n_err == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
